FILE: sv/perfect_number_filter_unit_assert.svh
// Assertion macros for the perfect number filter.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef PERFECT_NUMBER_FILTER_UNIT_ASSERT_SVH
`define PERFECT_NUMBER_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, reset masked.
`define PNF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked.
`define PNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pnf_pkg.sv
// Shared constants for the perfect number filter.
// No dependencies.
package pnf_pkg;

  localparam int DATA_BITS          = 16;  // width of the value and result ports
  localparam int VALUE_BITS_DEFAULT = 16;  // default width of the tested number

endpackage

FILE: sv/perfect_number_filter_unit.sv
// Perfect number filter: tests each input number and passes on the perfect ones.
//
// Input channel: in_valid / in_stall / value. One number is taken per transfer;
// only its low VALUE_BITS bits are tested. in_stall is high while a number is
// being worked on, so one number is in flight at a time.
// Output channel: out_valid / out_stall / perfect_value. A number whose proper
// divisor sum equals itself is sent once; any other number (zero and one too)
// produces no transfer.
// Search: trial divisors d = 1, 2, ... run while d <= n / d. Each trial is one
// bit-serial restoring division over all VALUE_BITS quotient bits in the shared
// subtract/compare unit, then an accumulate step; zero is dropped without a search.
// The search stops early once the running sum passes the number.
// Reset: rst (synchronous) empties the block and drops any pending result.
// Output stall: a finished perfect number waits in the block until the output
// register is free; meanwhile in_stall stays high.
// Depends on pnf_pkg and perfect_number_filter_unit_assert.svh.
module perfect_number_filter_unit #(
  parameter int VALUE_BITS = pnf_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pnf_pkg::DATA_BITS-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pnf_pkg::DATA_BITS-1:0] perfect_value
);
  import pnf_pkg::*;

  localparam int SUM_BITS = VALUE_BITS + 2;
  localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(VALUE_BITS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_ACCUM  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] quo;
  logic [CNT_BITS-1:0]   cnt;
  logic [SUM_BITS-1:0]   sum;
  logic                  over;

  logic [VALUE_BITS-1:0] n_in;
  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS:0]   d_ext;
  logic [VALUE_BITS:0]   rem_diff;
  logic                  rem_ge;
  logic [SUM_BITS-1:0]   n_ext;
  logic [SUM_BITS-1:0]   term_d;
  logic [SUM_BITS-1:0]   term_q;
  logic [SUM_BITS-1:0]   sum_next;
  logic                  is_perfect;
  logic                  out_free;
  logic                  out_load;

  assign n_in     = VALUE_BITS'(value);
  assign in_stall = (state != ST_IDLE);

  // Shared restoring-division step: shift in next dividend bit, try subtract.
  assign rem_shift = {rem, quo[VALUE_BITS-1]};
  assign d_ext     = {1'b0, d};
  assign rem_diff  = rem_shift - d_ext;
  assign rem_ge    = (rem_shift >= d_ext);

  // Divisor pair d and n/d; skip n itself and the repeated square root.
  assign n_ext    = {2'b00, n};
  assign term_d   = (d != n) ? {2'b00, d} : '0;
  assign term_q   = ((quo != d) && (quo != n)) ? {2'b00, quo} : '0;
  assign sum_next = sum + term_d + term_q;

  assign is_perfect = !over && (sum == n_ext);
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = (state == ST_FINISH) && is_perfect && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      over      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && (n_in != '0)) begin
            n     <= n_in;
            d     <= VALUE_BITS'(1);
            rem   <= '0;
            quo   <= n_in;
            cnt   <= '0;
            sum   <= '0;
            over  <= 1'b0;
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          rem <= rem_ge ? rem_diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
          quo <= {quo[VALUE_BITS-2:0], rem_ge};
          cnt <= cnt + CNT_BITS'(1);
          if (cnt == LAST_STEP) begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if ((quo < d) || over) begin
            state <= ST_FINISH;
          end else begin
            if (rem == '0) begin
              sum <= sum_next;
              if (sum_next > n_ext) begin
                over <= 1'b1;
              end
            end
            // Advance to the next trial divisor.
            d     <= d + VALUE_BITS'(1);
            rem   <= '0;
            quo   <= n;
            cnt   <= '0;
            state <= ST_DIVIDE;
          end
        end
        ST_FINISH: begin
          if (!is_perfect) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            perfect_value <= DATA_BITS'(n);
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "perfect_number_filter_unit_assert.svh"

  `PNF_ASSERT_NEXT(a_start_divide, in_valid && !in_stall && (n_in != '0), state == ST_DIVIDE, "nonzero transfer did not start a division")
  `PNF_ASSERT_NEXT(a_full_divide, (state == ST_DIVIDE) && (cnt != LAST_STEP), state == ST_DIVIDE, "division left before all steps")
  `PNF_ASSERT_NOW(a_over_means_above, over, sum > n_ext, "overflow flag set with sum not above number")
  `PNF_ASSERT_NEXT(a_result_is_perfect, (state == ST_FINISH) && out_free && !(out_valid && !out_stall), out_valid == $past(is_perfect), "result load does not match divisor sum")

endmodule
